// ===== design/ipd_pkg.sv =====
// Shared types, widths and reset values for the incremental PID deadband core.
// No dependencies; every other design file refers to this package by scoped names.
package ipd_pkg;

   // payload and arithmetic widths
   localparam int DATA_W  = 16;          // target, measured, drive, gains, period
   localparam int CNT_W   = DATA_W + 1;  // tick count plus carry for the compare
   localparam int ERR_W   = 17;          // target - measured
   localparam int D1_W    = 18;          // first difference of the error
   localparam int D2_W    = 19;          // second difference of the error
   localparam int PROD_W  = 35;          // gain times difference, exact
   localparam int INC_W   = 36;          // sum of the three products
   localparam int SUM_W   = 37;          // drive plus increment before the clamp
   localparam int ACC_W   = 24;          // clamped drive in Q.8
   localparam int FRAC_W  = 8;           // fraction bits of the drive
   localparam int DB_W    = 8;
   localparam int LIMIT_W = 15;
   localparam int LIM_W   = LIMIT_W + FRAC_W;
   localparam int CSR_W   = 32;
   localparam int ADDR_W  = 5;

   // register reset values
   localparam logic signed [DATA_W-1:0]  GAIN_PROP_RST  = 16'sd128;
   localparam logic signed [DATA_W-1:0]  GAIN_INTEG_RST = 16'sd10;
   localparam logic signed [DATA_W-1:0]  GAIN_DERIV_RST = -16'sd38;
   localparam logic        [DB_W-1:0]    DEADBAND_RST   = 8'd3;
   localparam logic        [DATA_W-1:0]  PERIOD_RST     = 16'd20;
   localparam logic        [LIMIT_W-1:0] LIMIT_RST      = 15'd100;

   // register map, word index = paddr / 4
   typedef enum logic [2:0] {
      REG_GAIN_PROP  = 3'd0,
      REG_GAIN_INTEG = 3'd1,
      REG_GAIN_DERIV = 3'd2,
      REG_DEADBAND   = 3'd3,
      REG_PERIOD     = 3'd4,
      REG_LIMIT      = 3'd5
   } reg_index_type;

   typedef struct packed {
      logic signed [DATA_W-1:0] gain_prop;
      logic signed [DATA_W-1:0] gain_integ;
      logic signed [DATA_W-1:0] gain_deriv;
      logic        [DB_W-1:0]   deadband;
      logic        [DATA_W-1:0] update_period;
      logic        [LIMIT_W-1:0] out_limit;
   } cfg_type;

   // products stage to accumulator stage
   typedef struct packed {
      logic signed [PROD_W-1:0] p_term;
      logic signed [PROD_W-1:0] i_term;
      logic signed [PROD_W-1:0] d_term;
      logic                     db_hit;
      logic                     motor;
   } prod_type;

endpackage

// ===== design/ipd_req_if.sv =====
// Input channel: one timer tick word with setpoint, measurement and selects.
// Depends on ipd_pkg for the field widths.
interface ipd_req_if;
   logic                             valid;
   logic                             ready;
   logic signed [ipd_pkg::DATA_W-1:0] target;
   logic signed [ipd_pkg::DATA_W-1:0] measured;
   logic                             deadband_on;
   logic                             motor_sel;

   modport source (output valid, target, measured, deadband_on, motor_sel, input ready);
   modport sink   (input valid, target, measured, deadband_on, motor_sel, output ready);
endinterface

// ===== design/ipd_rsp_if.sv =====
// Result channel: one drive word per control update.
// Depends on ipd_pkg for the field widths.
interface ipd_rsp_if;
   logic                             valid;
   logic                             ready;
   logic signed [ipd_pkg::DATA_W-1:0] drive;
   logic                             motor_out;

   modport source (output valid, drive, motor_out, input ready);
   modport sink   (input valid, drive, motor_out, output ready);
endinterface

// ===== design/ipd_csr.sv =====
// APB-style register block holding gains, deadband, update period and limit.
// Depends on ipd_pkg.
module ipd_csr (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       psel,
   input  logic                       penable,
   input  logic                       pwrite,
   input  logic [ipd_pkg::ADDR_W-1:0] paddr,
   input  logic [ipd_pkg::CSR_W-1:0]  pwdata,
   output logic [ipd_pkg::CSR_W-1:0]  prdata,
   output logic                       pready,
   output ipd_pkg::cfg_type           cfg
);

   ipd_pkg::cfg_type       cfg_ff, cfg_in;
   ipd_pkg::reg_index_type index;
   logic                   wr_en;

   assign index  = ipd_pkg::reg_index_type'(paddr[ipd_pkg::ADDR_W-1:2]);
   assign wr_en  = psel & penable & pwrite;
   assign pready = 1'b1;
   assign cfg    = cfg_ff;

   // register write decode
   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         unique case (index)
            ipd_pkg::REG_GAIN_PROP:  cfg_in.gain_prop  = pwdata[ipd_pkg::DATA_W-1:0];
            ipd_pkg::REG_GAIN_INTEG: cfg_in.gain_integ = pwdata[ipd_pkg::DATA_W-1:0];
            ipd_pkg::REG_GAIN_DERIV: cfg_in.gain_deriv = pwdata[ipd_pkg::DATA_W-1:0];
            ipd_pkg::REG_DEADBAND:   cfg_in.deadband   = pwdata[ipd_pkg::DB_W-1:0];
            ipd_pkg::REG_PERIOD:     cfg_in.update_period = pwdata[ipd_pkg::DATA_W-1:0];
            ipd_pkg::REG_LIMIT:      cfg_in.out_limit  = pwdata[ipd_pkg::LIMIT_W-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.gain_prop     <= ipd_pkg::GAIN_PROP_RST;
         cfg_ff.gain_integ    <= ipd_pkg::GAIN_INTEG_RST;
         cfg_ff.gain_deriv    <= ipd_pkg::GAIN_DERIV_RST;
         cfg_ff.deadband      <= ipd_pkg::DEADBAND_RST;
         cfg_ff.update_period <= ipd_pkg::PERIOD_RST;
         cfg_ff.out_limit     <= ipd_pkg::LIMIT_RST;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // read-back, zero extended
   always_comb begin
      unique case (index)
         ipd_pkg::REG_GAIN_PROP:
            prdata = {{(ipd_pkg::CSR_W-ipd_pkg::DATA_W){1'b0}}, cfg_ff.gain_prop};
         ipd_pkg::REG_GAIN_INTEG:
            prdata = {{(ipd_pkg::CSR_W-ipd_pkg::DATA_W){1'b0}}, cfg_ff.gain_integ};
         ipd_pkg::REG_GAIN_DERIV:
            prdata = {{(ipd_pkg::CSR_W-ipd_pkg::DATA_W){1'b0}}, cfg_ff.gain_deriv};
         ipd_pkg::REG_DEADBAND:
            prdata = {{(ipd_pkg::CSR_W-ipd_pkg::DB_W){1'b0}}, cfg_ff.deadband};
         ipd_pkg::REG_PERIOD:
            prdata = {{(ipd_pkg::CSR_W-ipd_pkg::DATA_W){1'b0}}, cfg_ff.update_period};
         ipd_pkg::REG_LIMIT:
            prdata = {{(ipd_pkg::CSR_W-ipd_pkg::LIMIT_W){1'b0}}, cfg_ff.out_limit};
         default:
            prdata = '0;
      endcase
   end

endmodule

// ===== design/ipd_front.sv =====
// Tick counter, input register, error history and the three gain products.
// Depends on ipd_pkg and ipd_req_if.
module ipd_front (
   input  logic              clock,
   input  logic              reset,
   input  ipd_pkg::cfg_type  cfg,
   ipd_req_if.sink           req_chan,
   output logic              prod_valid,
   input  logic              prod_ready,
   output ipd_pkg::prod_type prod
);

   logic [ipd_pkg::DATA_W-1:0] tick_count_ff, tick_count_in;
   logic [ipd_pkg::CNT_W-1:0]  tick_next;
   logic                       update;
   logic                       accept;

   logic                              s1_valid_ff, s1_valid_in;
   logic signed [ipd_pkg::DATA_W-1:0] s1_target_ff, s1_measured_ff;
   logic                              s1_db_on_ff, s1_motor_ff;
   logic                              s1_move;

   logic signed [ipd_pkg::ERR_W-1:0] err_now_ff, err_prev_ff;
   logic signed [ipd_pkg::ERR_W-1:0] err_new;
   logic signed [ipd_pkg::D1_W-1:0]  diff1;
   logic signed [ipd_pkg::D2_W-1:0]  diff2;
   logic signed [ipd_pkg::ERR_W-1:0] db_lim;

   logic              prod_valid_ff, prod_valid_in;
   ipd_pkg::prod_type prod_ff, prod_in;

   // tick counting: an update when count+1 reaches the period
   assign tick_next     = {1'b0, tick_count_ff} + ipd_pkg::CNT_W'(1);
   assign update        = tick_next >= {1'b0, cfg.update_period};
   assign accept        = req_chan.valid & req_chan.ready;
   assign tick_count_in = update ? '0 : tick_next[ipd_pkg::DATA_W-1:0];

   // handshake: each stage loads when empty or when it hands on
   assign s1_move        = s1_valid_ff & (~prod_valid_ff | prod_ready);
   assign req_chan.ready = ~s1_valid_ff | s1_move;
   assign s1_valid_in    = (accept & update) | (s1_valid_ff & ~s1_move);
   assign prod_valid_in  = s1_move | (prod_valid_ff & ~prod_ready);

   // error and its differences against the history
   assign err_new = ipd_pkg::ERR_W'(s1_target_ff) - ipd_pkg::ERR_W'(s1_measured_ff);
   assign diff1   = ipd_pkg::D1_W'(err_new) - ipd_pkg::D1_W'(err_now_ff);
   assign diff2   = ipd_pkg::D2_W'(err_new) - (ipd_pkg::D2_W'(err_now_ff) <<< 1)
                    + ipd_pkg::D2_W'(err_prev_ff);
   assign db_lim  = $signed({{(ipd_pkg::ERR_W-ipd_pkg::DB_W){1'b0}}, cfg.deadband});

   // products, one multiplier per term
   always_comb begin
      prod_in.p_term = ipd_pkg::PROD_W'(cfg.gain_prop)  * ipd_pkg::PROD_W'(diff1);
      prod_in.i_term = ipd_pkg::PROD_W'(cfg.gain_integ) * ipd_pkg::PROD_W'(err_new);
      prod_in.d_term = ipd_pkg::PROD_W'(cfg.gain_deriv) * ipd_pkg::PROD_W'(diff2);
      prod_in.db_hit = s1_db_on_ff & (err_new >= -db_lim) & (err_new <= db_lim);
      prod_in.motor  = s1_motor_ff;
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         tick_count_ff <= '0;
         s1_valid_ff   <= 1'b0;
         prod_valid_ff <= 1'b0;
         err_now_ff    <= '0;
         err_prev_ff   <= '0;
      end else begin
         if (accept) begin
            tick_count_ff <= tick_count_in;
         end
         s1_valid_ff   <= s1_valid_in;
         prod_valid_ff <= prod_valid_in;
         if (s1_move) begin
            err_prev_ff <= err_now_ff;
            err_now_ff  <= err_new;
         end
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (accept & update & req_chan.ready) begin
         s1_target_ff   <= req_chan.target;
         s1_measured_ff <= req_chan.measured;
         s1_db_on_ff    <= req_chan.deadband_on;
         s1_motor_ff    <= req_chan.motor_sel;
      end
      if (s1_move) begin
         prod_ff <= prod_in;
      end
   end

   assign prod_valid = prod_valid_ff;
   assign prod       = prod_ff;

endmodule

// ===== design/ipd_accum.sv =====
// Drive accumulator: sums the increment, applies deadband and clamp, result register.
// Depends on ipd_pkg and ipd_rsp_if.
module ipd_accum (
   input  logic              clock,
   input  logic              reset,
   input  ipd_pkg::cfg_type  cfg,
   input  logic              prod_valid,
   output logic              prod_ready,
   input  ipd_pkg::prod_type prod,
   ipd_rsp_if.source         rsp_chan
);

   logic signed [ipd_pkg::ACC_W-1:0]  acc_ff, acc_in;
   logic signed [ipd_pkg::INC_W-1:0]  incr;
   logic signed [ipd_pkg::SUM_W-1:0]  sum;
   logic signed [ipd_pkg::SUM_W-1:0]  lim;
   logic signed [ipd_pkg::ACC_W-1:0]  acc_bias;
   logic signed [ipd_pkg::DATA_W-1:0] drive_in;
   logic                              take;

   logic                              rsp_valid_ff, rsp_valid_in;
   logic signed [ipd_pkg::DATA_W-1:0] drive_ff;
   logic                              motor_ff;

   assign prod_ready   = ~rsp_valid_ff | rsp_chan.ready;
   assign take         = prod_valid & prod_ready;
   assign rsp_valid_in = take | (rsp_valid_ff & ~rsp_chan.ready);

   // increment and new drive; deadband forces zero
   assign incr = ipd_pkg::INC_W'(prod.p_term) + ipd_pkg::INC_W'(prod.i_term)
                 + ipd_pkg::INC_W'(prod.d_term);
   assign sum  = prod.db_hit ? '0 : ipd_pkg::SUM_W'(acc_ff) + ipd_pkg::SUM_W'(incr);
   assign lim  = $signed({{(ipd_pkg::SUM_W-ipd_pkg::LIM_W){1'b0}},
                          cfg.out_limit, {ipd_pkg::FRAC_W{1'b0}}});

   // symmetric clamp, upper bound first
   always_comb begin
      priority if (sum >= lim) begin
         acc_in = lim[ipd_pkg::ACC_W-1:0];
      end else if (sum <= -lim) begin
         acc_in = -lim[ipd_pkg::ACC_W-1:0];
      end else begin
         acc_in = sum[ipd_pkg::ACC_W-1:0];
      end
   end

   // truncate toward zero: bias negatives by one less than a unit
   assign acc_bias = acc_in[ipd_pkg::ACC_W-1]
                     ? acc_in + ipd_pkg::ACC_W'((1 << ipd_pkg::FRAC_W) - 1) : acc_in;
   assign drive_in = ipd_pkg::DATA_W'(acc_bias >>> ipd_pkg::FRAC_W);

   always_ff @(posedge clock) begin
      if (reset) begin
         acc_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         if (take) begin
            acc_ff <= acc_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         drive_ff <= drive_in;
         motor_ff <= prod.motor;
      end
   end

   assign rsp_chan.valid     = rsp_valid_ff;
   assign rsp_chan.drive     = drive_ff;
   assign rsp_chan.motor_out = motor_ff;

endmodule

// ===== design/incremental_pid_deadband_core.sv =====
// Incremental PID with deadband: a tick word is accepted every cycle unless the result side stalls.
// An update tick gives its drive word after passing the input register, product
// register and result register; other ticks give nothing. Throughput is
// one tick per cycle, limited only by the result side taking words.
// Synchronous reset restores the register defaults and clears the tick count,
// error history and drive accumulator.
module incremental_pid_deadband_core (
   input  logic                       clock,
   input  logic                       reset,
   ipd_req_if.sink                    req_chan,
   ipd_rsp_if.source                  rsp_chan,
   input  logic                       psel,
   input  logic                       penable,
   input  logic                       pwrite,
   input  logic [ipd_pkg::ADDR_W-1:0] paddr,
   input  logic [ipd_pkg::CSR_W-1:0]  pwdata,
   output logic [ipd_pkg::CSR_W-1:0]  prdata,
   output logic                       pready
);

   ipd_pkg::cfg_type  cfg;
   ipd_pkg::prod_type prod;
   logic              prod_valid;
   logic              prod_ready;

   ipd_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .cfg     (cfg)
   );

   ipd_front u_front (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg),
      .req_chan   (req_chan),
      .prod_valid (prod_valid),
      .prod_ready (prod_ready),
      .prod       (prod)
   );

   ipd_accum u_accum (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg),
      .prod_valid (prod_valid),
      .prod_ready (prod_ready),
      .prod       (prod),
      .rsp_chan   (rsp_chan)
   );

`ifndef NO_ASSERTIONS
   // drive word never exceeds the configured limit
   a_drive_limit: assert property (@(posedge clock) disable iff (reset)
      rsp_chan.valid |->
         ($signed(rsp_chan.drive) <= $signed({1'b0, cfg.out_limit})) &&
         ($signed(rsp_chan.drive) >= -$signed({1'b0, cfg.out_limit})))
      else $error("drive outside limit");

   // a stalled product word holds until the accumulator takes it
   a_prod_hold: assert property (@(posedge clock) disable iff (reset)
      (prod_valid && !prod_ready) |=> (prod_valid && $stable(prod)))
      else $error("product word lost while stalled");

   // accumulator never moves while a result word waits untaken
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      (rsp_chan.valid && !rsp_chan.ready) |-> !prod_ready)
      else $error("result word overwritten");
`endif

endmodule
